// ----- rtl/utf8d_pkg.sv -----
`timescale 1ns / 1ps

package utf8d_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned HeldW    = 2;
  localparam int unsigned PartialW = 18;
  localparam int unsigned CpW      = 21;
  localparam int unsigned LenW     = 3;

  localparam logic [ByteW-1:0] SurrLead = 8'hED;
  localparam logic [ByteW-1:0] SurrMask = 8'hA0;
  localparam logic [ByteW-1:0] DropMark = 8'h00;
  localparam logic [ByteW-1:0] Lead2Lo  = 8'd192;
  localparam logic [ByteW-1:0] Lead3Lo  = 8'd224;
  localparam logic [ByteW-1:0] Lead4Lo  = 8'd240;
  localparam logic [ByteW-1:0] Lead4Hi  = 8'd247;

  localparam logic [HeldW-1:0] HeldNone = 2'd0;
  localparam logic [HeldW-1:0] HeldLead = 2'd1;
  localparam logic [HeldW-1:0] HeldTwo  = 2'd2;

  typedef struct packed {
    logic [ByteW-1:0]    lead;
    logic [HeldW-1:0]    held;
    logic [PartialW-1:0] partial;
  } utf8d_state_t;

  typedef struct packed {
    utf8d_state_t     nxt;
    logic             emit;
    logic [CpW-1:0]   cp;
  } utf8d_step_t;

  function automatic logic [LenW-1:0] utf8d_seq_len(input logic [ByteW-1:0] lead);
    logic [LenW-1:0] len;
    if (!lead[7]) begin
      len = 3'd3;
    end else if (lead >= Lead2Lo && lead < Lead3Lo) begin
      len = 3'd2;
    end else if (lead >= Lead3Lo && lead < Lead4Lo) begin
      len = 3'd3;
    end else begin
      len = 3'd4;
    end
    return len;
  endfunction

  function automatic logic utf8d_lead_ok(input logic [ByteW-1:0] lead);
    return (lead >= Lead2Lo) && (lead <= Lead4Hi);
  endfunction

endpackage

// ----- rtl/utf8_byte_stream_decoder.sv -----
`timescale 1ns / 1ps
// A code point enters the output register when the byte closing its sequence
// advances from the input register.
// Throughput: one byte per cycle; the sequence state updates from the input
// register. A byte waits there while an untaken output beat is held.
// Reset (rst_ni low, asynchronous): empties both registers and closes any open
// sequence.

module utf8_byte_stream_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        string_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [20:0] code_point_o
);
  import utf8d_pkg::*;

  logic           in_vld_q;
  logic [7:0]     byte_q;
  logic           end_q;
  utf8d_state_t   state_q;
  logic           out_vld_q;
  logic [CpW-1:0] cp_q;
  logic           advance;
  utf8d_step_t    step;

  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  utf8d_next u_next (
    .state_i      (state_q),
    .data_byte_i  (byte_q),
    .string_end_i (end_q),
    .step_o       (step)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      state_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (advance) begin
        state_q   <= step.nxt;
        out_vld_q <= step.emit;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= data_byte_i;
      end_q  <= string_end_i;
    end
    if (advance && step.emit) begin
      cp_q <= step.cp;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign code_point_o = cp_q;

  a_end_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && end_q |=> state_q.held == HeldNone)
    else $error("sequence left open after string end");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.held == HeldNone |-> state_q.lead == DropMark && state_q.partial == '0)
    else $error("stale sequence state with no sequence open");

  a_emit_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && step.emit |=> out_vld_q && cp_q == $past(step.cp))
    else $error("completed code point not registered");

endmodule

// ----- rtl/utf8d_next.sv -----
`timescale 1ns / 1ps

module utf8d_next (
  input  utf8d_pkg::utf8d_state_t state_i,
  input  logic [7:0]              data_byte_i,
  input  logic                    string_end_i,
  output utf8d_pkg::utf8d_step_t  step_o
);
  import utf8d_pkg::*;

  logic [5:0]      cont;
  logic [LenW-1:0] total;
  logic [LenW-1:0] n;
  logic [CpW-1:0]  lead_part;
  logic [CpW-1:0]  full_cp;
  utf8d_step_t     step;

  assign cont  = data_byte_i[5:0];
  assign total = utf8d_seq_len(state_i.lead);
  assign n     = {1'b0, state_i.held} + 3'd1;

  always_comb begin
    case (total)
      3'd2:    lead_part = {10'd0, state_i.lead[4:0], 6'd0};
      3'd3:    lead_part = {5'd0, state_i.lead[3:0], 12'd0};
      default: lead_part = {state_i.lead[2:0], 18'd0};
    endcase
  end

  assign full_cp = lead_part | {state_i.partial[14:0], 6'd0} | {15'd0, cont};

  always_comb begin
    step      = '0;
    step.nxt  = state_i;
    if (state_i.held == HeldNone) begin
      if (!data_byte_i[7]) begin
        step.emit = 1'b1;
        step.cp   = {13'd0, data_byte_i};
      end else begin
        step.nxt.lead    = data_byte_i;
        step.nxt.held    = HeldLead;
        step.nxt.partial = '0;
      end
    end else if (state_i.held == HeldLead && state_i.lead == SurrLead &&
                 (data_byte_i & SurrMask) == SurrMask) begin
      // drop the whole surrogate sequence
      step.nxt.lead    = DropMark;
      step.nxt.held    = HeldTwo;
      step.nxt.partial = '0;
    end else if (n >= total) begin
      step.emit = utf8d_lead_ok(state_i.lead);
      step.cp   = full_cp;
      step.nxt  = '0;
    end else begin
      step.nxt.held    = n[HeldW-1:0];
      step.nxt.partial = {state_i.partial[11:0], cont};
    end
    if (string_end_i && step.nxt.held != HeldNone) begin
      step.nxt = '0;
    end
  end

  assign step_o = step;

endmodule

// ----- bench/utf8_byte_stream_decoder_checker.sv -----
`timescale 1ns / 1ps

module utf8_byte_stream_decoder_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic [utf8d_pkg::ByteW-1:0] data_byte_i,
  input  logic                        string_end_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic [utf8d_pkg::CpW-1:0]   code_point_i,
  output int unsigned                 mismatches_o,
  output int unsigned                 awaited_o,
  output int unsigned                 bytes_o,
  output int unsigned                 code_points_o
);
  import utf8d_pkg::*;

  logic [ByteW-1:0]    seq_lead;
  logic [HeldW-1:0]    seq_held;
  logic [PartialW-1:0] seq_bits;
  logic [CpW-1:0]      cp_expected_q[$];
  logic [CpW-1:0]      cp_want;

  function automatic int unsigned span_of(input logic [ByteW-1:0] lead);
    if (lead < 8'd128) begin
      return 3;
    end else if (lead >= Lead2Lo && lead < Lead3Lo) begin
      return 2;
    end else if (lead >= Lead3Lo && lead < Lead4Lo) begin
      return 3;
    end
    return 4;
  endfunction

  task automatic predict_cp(input logic [CpW-1:0] value);
    cp_expected_q.insert(cp_expected_q.size(), value);
  endtask

  task automatic clear_sequence();
    seq_lead = '0;
    seq_held = HeldNone;
    seq_bits = '0;
  endtask

  task automatic decode_byte(input logic [ByteW-1:0] b, input logic last);
    logic [5:0]  grp;
    int unsigned n;
    int unsigned total;
    int unsigned lead_pay;
    int unsigned cp;
    grp = b[5:0];
    if (seq_held == HeldNone) begin
      if (!b[7]) begin
        predict_cp(CpW'(b));
      end else begin
        seq_lead = b;
        seq_held = HeldLead;
        seq_bits = '0;
      end
    end else begin
      n     = seq_held + 1;
      total = span_of(seq_lead);
      if (n == 2 && seq_lead == SurrLead && (b & SurrMask) == SurrMask) begin
        // drop the rest of the surrogate
        seq_lead = DropMark;
        seq_held = HeldTwo;
        seq_bits = '0;
      end else if (n >= total) begin
        if (seq_lead >= Lead2Lo && seq_lead <= Lead4Hi) begin
          if (total == 2) begin
            lead_pay = seq_lead - Lead2Lo;
          end else if (total == 3) begin
            lead_pay = seq_lead - Lead3Lo;
          end else begin
            lead_pay = seq_lead - Lead4Lo;
          end
          cp = (lead_pay << (6 * (total - 1))) | ((32'(seq_bits) << 6) & 32'h3F_FFFF)
               | 32'(grp);
          predict_cp(CpW'(cp));
        end
        clear_sequence();
      end else begin
        seq_held = HeldW'(n);
        seq_bits = PartialW'({seq_bits, grp});
      end
    end
    if (last && seq_held != HeldNone) begin
      clear_sequence();
    end
  endtask

  task automatic report_mismatch(input string what);
    mismatches_o <= mismatches_o + 1;
    $display("%0t ns: code point check: %s", $realtime, what);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_sequence();
      cp_expected_q.delete();
      mismatches_o  <= 0;
      awaited_o     <= 0;
      bytes_o       <= 0;
      code_points_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        decode_byte(data_byte_i, string_end_i);
        bytes_o <= bytes_o + 1;
      end
      if (out_valid_i && out_ready_i) begin
        if (cp_expected_q.size() == 0) begin
          report_mismatch($sformatf("unexpected beat 0x%06h", code_point_i));
        end else begin
          cp_want = cp_expected_q.pop_front();
          code_points_o <= code_points_o + 1;
          if (code_point_i !== cp_want) begin
            report_mismatch($sformatf("got 0x%06h, want 0x%06h", code_point_i, cp_want));
          end
        end
      end
      awaited_o <= cp_expected_q.size();
    end
  end

endmodule

// ----- bench/utf8_byte_stream_decoder_tb.sv -----
`timescale 1ns / 1ps

module utf8_byte_stream_decoder_tb;
  import utf8d_pkg::*;

  localparam int unsigned IdleLimit   = 1000;
  localparam int unsigned RandomBytes = 1330;
  localparam int unsigned DrainCycles = 8;

  localparam logic [ByteW:0] Directed [23] = '{
    {1'b0, 8'h00}, {1'b0, 8'h7F},
    {1'b0, 8'hDF}, {1'b0, 8'hBF},
    {1'b0, 8'hE0}, {1'b0, 8'h80}, {1'b0, 8'h80},
    {1'b0, 8'hF7}, {1'b0, 8'hBF}, {1'b0, 8'hBF}, {1'b0, 8'hBF},
    {1'b0, 8'hED}, {1'b0, 8'hA0}, {1'b0, 8'h80},
    {1'b0, 8'hED}, {1'b0, 8'h9F}, {1'b0, 8'hBF},
    {1'b0, 8'hF8}, {1'b0, 8'h41}, {1'b0, 8'h42}, {1'b0, 8'h43},
    {1'b1, 8'hC2}, {1'b1, 8'h41}
  };

  typedef enum logic [1:0] {RxFlow, RxJitter, RxBlock} rx_mode_e;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_valid   = 1'b0;
  logic [ByteW-1:0] data_byte  = '0;
  logic             string_end = 1'b0;
  logic             out_ready  = 1'b0;
  logic             in_ready;
  logic             out_valid;
  logic [CpW-1:0]   code_point;

  int unsigned mismatches;
  int unsigned awaited;
  int unsigned bytes_seen;
  int unsigned cps_seen;

  int unsigned idle_cycles = 0;
  int unsigned burst_left  = 0;
  int unsigned sent        = 0;
  int unsigned stall_left  = 0;
  int unsigned mode_left   = 0;
  rx_mode_e    rx_mode     = RxFlow;
  logic [ByteW-1:0] str_q[$];

  always #2 clk = ~clk;

  utf8_byte_stream_decoder i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .data_byte_i  (data_byte),
    .string_end_i (string_end),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .code_point_o (code_point)
  );

  utf8_byte_stream_decoder_checker i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .data_byte_i   (data_byte),
    .string_end_i  (string_end),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .code_point_i  (code_point),
    .mismatches_o  (mismatches),
    .awaited_o     (awaited),
    .bytes_o       (bytes_seen),
    .code_points_o (cps_seen)
  );

  task automatic push_beat(input logic [ByteW-1:0] b, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid   <= 1'b1;
    data_byte  <= b;
    string_end <= last;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  function automatic logic [ByteW-1:0] cont_byte();
    if ($urandom_range(0, 7) == 0) begin
      return 8'($urandom);
    end
    return {2'b10, 6'($urandom)};
  endfunction

  task automatic queue_byte(input logic [ByteW-1:0] b);
    str_q.insert(str_q.size(), b);
  endtask

  task automatic add_chunk();
    int unsigned pick;
    int unsigned len;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      queue_byte(8'($urandom_range(0, 127)));
    end else if (pick < 70) begin
      len = $urandom_range(2, 4);
      if (len == 2) begin
        queue_byte(8'($urandom_range(Lead2Lo, Lead3Lo - 1)));
      end else if (len == 3) begin
        queue_byte(8'($urandom_range(Lead3Lo, Lead4Lo - 1)));
      end else begin
        queue_byte(8'($urandom_range(Lead4Lo, Lead4Hi)));
      end
      repeat (len - 1) queue_byte(cont_byte());
    end else if (pick < 80) begin
      queue_byte(SurrLead);
      queue_byte(SurrMask | 8'($urandom));
      queue_byte(cont_byte());
    end else if (pick < 90) begin
      queue_byte($urandom_range(0, 1) ? 8'($urandom_range(128, Lead2Lo - 1))
                                      : 8'($urandom_range(Lead4Hi + 1, 255)));
      repeat (3) queue_byte(8'($urandom));
    end else begin
      queue_byte(8'($urandom));
    end
  endtask

  always @(posedge clk) begin
    if (mode_left == 0) begin
      rx_mode   <= rx_mode_e'($urandom_range(0, 2));
      mode_left <= $urandom_range(50, 300);
    end else begin
      mode_left <= mode_left - 1;
    end
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (rx_mode == RxJitter && $urandom_range(0, 2) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else if (rx_mode == RxBlock && $urandom_range(0, 9) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(3, 16);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IdleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned target;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (Directed[k]) begin
      push_beat(Directed[k][ByteW-1:0], Directed[k][ByteW]);
    end

    while (sent < $size(Directed) + RandomBytes) begin
      target = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 40);
      while (str_q.size() < target) begin
        add_chunk();
      end
      // cut some strings short so that open sequences meet the end marker
      if ($urandom_range(0, 3) == 0) begin
        str_q = str_q[0:$urandom_range(0, str_q.size() - 1)];
      end
      foreach (str_q[k]) begin
        push_beat(str_q[k], k == str_q.size() - 1);
      end
      str_q.delete();
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Fed %0d bytes: ASCII, 2/3/4-byte forms, surrogates, bad leads, cut strings.",
             bytes_seen);
    $display("Compared %0d code points under bursty input and stalled output.", cps_seen);
    if (mismatches == 0 && awaited == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
